// ===== src/ssc_pkg.sv =====
package ssc_pkg;

	// Number of spatial axes handled side by side.
	localparam int unsigned AXES = 3;

	// Pipeline control shared by every stage of the block.
	typedef struct packed {
		logic adv;
	} pipe_ctl_t;

endpackage

// ===== src/sphere_sphere_contact_top.sv =====
// Channel | Direction | Handshake          | Payload
// in      | into      | in_valid/in_stall   | centre_a_*, centre_b_*, radius_a, radius_b
// out     | out of    | out_valid/out_stall | hit, normal_*, contact_*, penetration
//
// One pair is taken every cycle unless a result is held; each result passes through the front stages,
// the bit-per-stage root and divider pipelines and the output register.
// Reset clears only the valid bits of the stages and the output register.
// A stalled result holds the whole pipeline: in_stall rises in the same cycle, nothing is lost.
module sphere_sphere_contact_top #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] centre_a_x,
	input  logic signed [COORD_WIDTH-1:0] centre_a_y,
	input  logic signed [COORD_WIDTH-1:0] centre_a_z,
	input  logic signed [COORD_WIDTH-1:0] centre_b_x,
	input  logic signed [COORD_WIDTH-1:0] centre_b_y,
	input  logic signed [COORD_WIDTH-1:0] centre_b_z,
	input  logic [COORD_WIDTH-3:0]        radius_a,
	input  logic [COORD_WIDTH-3:0]        radius_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [FRAC_BITS+1:0]   normal_x,
	output logic signed [FRAC_BITS+1:0]   normal_y,
	output logic signed [FRAC_BITS+1:0]   normal_z,
	output logic signed [COORD_WIDTH-1:0] contact_x,
	output logic signed [COORD_WIDTH-1:0] contact_y,
	output logic signed [COORD_WIDTH-1:0] contact_z,
	output logic [COORD_WIDTH-2:0]        penetration
);

	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int RW = CW - 1;
	localparam int NA = ssc_pkg::AXES;

	typedef struct packed {
		logic             hit;
		logic [NA-1:0]    neg;
		logic [RW-1:0]    rsum;
		logic [NA*CW-1:0] mid;
		logic [NA*RW-1:0] adt;
	} root_sb_t;

	typedef struct packed {
		logic             hit;
		logic [NA-1:0]    neg;
		logic [RW-1:0]    pen;
		logic [NA*CW-1:0] mid;
	} div_sb_t;

	ssc_pkg::pipe_ctl_t ctl;

	// The whole pipeline moves unless a finished result is held.
	assign ctl.adv  = !(out_valid && out_stall);
	assign in_stall = !ctl.adv;

	logic signed [CW-1:0] ca [NA];
	logic signed [CW-1:0] cb [NA];
	assign ca = '{centre_a_x, centre_a_y, centre_a_z};
	assign cb = '{centre_b_x, centre_b_y, centre_b_z};

	// Stage 1: centre difference, its magnitude, midpoint and radius sum.
	logic [CW:0]    ad_s1  [NA];
	logic [NA-1:0]  neg_s1;
	logic [NA*CW-1:0] mid_s1;
	logic [RW-1:0]  rsum_s1;
	logic           v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [CW:0] d;
		logic signed [CW:0] sm;
		if (ctl.adv) begin
			for (int i = 0; i < NA; i++) begin
				d  = {ca[i][CW-1], ca[i]} - {cb[i][CW-1], cb[i]};
				sm = {ca[i][CW-1], ca[i]} + {cb[i][CW-1], cb[i]};
				ad_s1[i]              <= d[CW] ? (CW+1)'(-d) : d;
				neg_s1[i]             <= d[CW];
				mid_s1[i*CW +: CW]    <= sm[CW:1];
			end
			rsum_s1 <= {1'b0, radius_a} + {1'b0, radius_b};
		end
	end

	// Stage 2: axis reject and the squares.
	logic              far_s2;
	logic [RW-1:0]     adt_s2 [NA];
	logic [2*RW-1:0]   sq_s2  [NA];
	logic [2*RW-1:0]   rsq_s2;
	logic [NA-1:0]     neg_s2;
	logic [NA*CW-1:0]  mid_s2;
	logic [RW-1:0]     rsum_s2;
	logic              v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic far;
		if (ctl.adv) begin
			far = 1'b0;
			for (int i = 0; i < NA; i++) begin
				far       = far | (ad_s1[i] >= {2'b00, rsum_s1});
				adt_s2[i] <= ad_s1[i][RW-1:0];
				sq_s2[i]  <= ad_s1[i][RW-1:0] * ad_s1[i][RW-1:0];
			end
			far_s2  <= far;
			rsq_s2  <= rsum_s1 * rsum_s1;
			neg_s2  <= neg_s1;
			mid_s2  <= mid_s1;
			rsum_s2 <= rsum_s1;
		end
	end

	// Stage 3: squared length and the overlap decision.
	logic [2*CW-1:0] ssum;
	assign ssum = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	logic           v_s3;
	logic [2*RW-1:0] s_s3;
	root_sb_t       rsb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ctl.adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			s_s3        <= ssum[2*RW-1:0];
			rsb_s3.hit  <= !far_s2 && (ssum != '0) && ({2'b00, rsq_s2} > ssum);
			rsb_s3.neg  <= neg_s2;
			rsb_s3.rsum <= rsum_s2;
			rsb_s3.mid  <= mid_s2;
			for (int i = 0; i < NA; i++) begin
				rsb_s3.adt[i*RW +: RW] <= adt_s2[i];
			end
		end
	end

	// Length by square root.
	logic          v_rt;
	logic [RW-1:0] len_rt;
	root_sb_t      rsb_rt;

	ssc_sqrt #(.RW(RW), .SBW($bits(root_sb_t))) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.in_v   (v_s3),
		.rad    (s_s3),
		.sb_in  (rsb_s3),
		.out_v  (v_rt),
		.root   (len_rt),
		.sb_out (rsb_rt)
	);

	// Unit normal by division of each magnitude by the length.
	logic [RW-1:0] num_rt [NA];
	div_sb_t       dsb_rt;
	for (genvar i = 0; i < NA; i++) begin : g_num
		assign num_rt[i] = rsb_rt.adt[i*RW +: RW];
	end
	assign dsb_rt.hit = rsb_rt.hit;
	assign dsb_rt.neg = rsb_rt.neg;
	assign dsb_rt.pen = rsb_rt.rsum - len_rt;
	assign dsb_rt.mid = rsb_rt.mid;

	logic        v_dv;
	logic [FB:0] q_dv [NA];
	div_sb_t     dsb_dv;

	ssc_udiv #(.RW(RW), .FB(FB), .SBW($bits(div_sb_t))) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.in_v   (v_rt),
		.num    (num_rt),
		.den    (len_rt),
		.sb_in  (dsb_rt),
		.out_v  (v_dv),
		.quo    (q_dv),
		.sb_out (dsb_dv)
	);

	// Output register: apply signs and clear every field on a miss.
	logic [FB+1:0] nrm [NA];
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			nrm[i] = dsb_dv.neg[i] ? (FB+2)'(-{1'b0, q_dv[i]}) : {1'b0, q_dv[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.adv) begin
			out_valid <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			hit         <= dsb_dv.hit;
			normal_x    <= dsb_dv.hit ? nrm[0] : '0;
			normal_y    <= dsb_dv.hit ? nrm[1] : '0;
			normal_z    <= dsb_dv.hit ? nrm[2] : '0;
			contact_x   <= dsb_dv.hit ? dsb_dv.mid[0*CW +: CW] : '0;
			contact_y   <= dsb_dv.hit ? dsb_dv.mid[1*CW +: CW] : '0;
			contact_z   <= dsb_dv.hit ? dsb_dv.mid[2*CW +: CW] : '0;
			penetration <= dsb_dv.hit ? dsb_dv.pen : '0;
		end
	end

	// A held result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(penetration))
		else $error("held result changed");

	// An overlap always has a length strictly below the radius sum.
	a_pen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> penetration != '0)
		else $error("overlap with zero penetration");

	// A miss carries an all-zero result.
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> normal_x == '0 && normal_y == '0 && normal_z == '0
			&& penetration == '0)
		else $error("miss with non-zero fields");

	// Input is back-pressured exactly when the output is held.
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output hold");

endmodule

// ===== src/ssc_sqrt.sv =====
// Pipelined integer square root, one result bit resolved per stage.
module ssc_sqrt #(
	parameter int RW  = 31,
	parameter int SBW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssc_pkg::pipe_ctl_t ctl,
	input  logic               in_v,
	input  logic [2*RW-1:0]    rad,
	input  logic [SBW-1:0]     sb_in,
	output logic               out_v,
	output logic [RW-1:0]      root,
	output logic [SBW-1:0]     sb_out
);

	localparam int SW = 2 * RW;

	logic [SW-1:0]  rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [SBW-1:0] sb_s   [RW];
	logic           v_s    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [SW-1:0]  rem_in;
		logic [RW-1:0]  root_in;
		logic [SBW-1:0] sb_k;
		logic           v_in;
		logic [SW-1:0]  trial;
		logic           fits;

		if (k == 0) begin : g_first
			assign rem_in  = rad;
			assign root_in = '0;
			assign sb_k    = sb_in;
			assign v_in    = in_v;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign sb_k    = sb_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// Trial term is 2*root*2^B + 2^(2B); accept the bit if it fits the remainder.
		assign trial = ({{RW{1'b0}}, root_in} << (B + 1)) | (SW'(1) << (2 * B));
		assign fits  = trial <= rem_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ctl.adv) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[k]  <= fits ? rem_in - trial : rem_in;
				root_s[k] <= fits ? (root_in | (RW'(1) << B)) : root_in;
				sb_s[k]   <= sb_k;
			end
		end
	end

	assign out_v  = v_s[RW-1];
	assign root   = root_s[RW-1];
	assign sb_out = sb_s[RW-1];

endmodule

// ===== src/ssc_udiv.sv =====
// Pipelined restoring divider for the three normal components, one quotient bit a stage,
// with a final round-half-up stage.
module ssc_udiv #(
	parameter int RW  = 31,
	parameter int FB  = 16,
	parameter int SBW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssc_pkg::pipe_ctl_t ctl,
	input  logic               in_v,
	input  logic [RW-1:0]      num [ssc_pkg::AXES],
	input  logic [RW-1:0]      den,
	input  logic [SBW-1:0]     sb_in,
	output logic               out_v,
	output logic [FB:0]        quo [ssc_pkg::AXES],
	output logic [SBW-1:0]     sb_out
);

	localparam int NS = FB + 2;

	logic [RW:0]    r_s   [NS][ssc_pkg::AXES];
	logic [FB:0]    q_s   [NS][ssc_pkg::AXES];
	logic [RW-1:0]  den_s [NS];
	logic [SBW-1:0] sb_s  [NS];
	logic           v_s   [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [RW-1:0]  den_in;
		logic [SBW-1:0] sb_j;
		logic           v_in;
		logic [RW:0]    r_nx [ssc_pkg::AXES];
		logic [FB:0]    q_nx [ssc_pkg::AXES];

		if (j == 0) begin : g_first
			assign den_in = den;
			assign sb_j   = sb_in;
			assign v_in   = in_v;
		end else begin : g_next
			assign den_in = den_s[j-1];
			assign sb_j   = sb_s[j-1];
			assign v_in   = v_s[j-1];
		end

		for (genvar a = 0; a < ssc_pkg::AXES; a++) begin : g_lane
			logic [RW:0] r2;
			logic        ge;
			if (j == 0) begin : g_int
				// Integer bit: the numerator never exceeds the divisor.
				assign r2      = {1'b0, num[a]};
				assign ge      = r2 >= {1'b0, den_in};
				assign r_nx[a] = ge ? r2 - {1'b0, den_in} : r2;
				assign q_nx[a] = {{FB{1'b0}}, ge};
			end else if (j <= FB) begin : g_frac
				assign r2      = r_s[j-1][a] << 1;
				assign ge      = r2 >= {1'b0, den_in};
				assign r_nx[a] = ge ? r2 - {1'b0, den_in} : r2;
				assign q_nx[a] = {q_s[j-1][a][FB-1:0], ge};
			end else begin : g_round
				// Round to nearest: twice the remainder against the divisor.
				assign r2      = r_s[j-1][a] << 1;
				assign ge      = r2 >= {1'b0, den_in};
				assign r_nx[a] = r2;
				assign q_nx[a] = q_s[j-1][a] + {{FB{1'b0}}, ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (ctl.adv) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				r_s[j]   <= r_nx;
				q_s[j]   <= q_nx;
				den_s[j] <= den_in;
				sb_s[j]  <= sb_j;
			end
		end
	end

	assign out_v  = v_s[NS-1];
	assign quo    = q_s[NS-1];
	assign sb_out = sb_s[NS-1];

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int FB = 16;
	localparam int CW = 32;
	localparam int LATENCY = 53;

	typedef struct packed {
		logic signed [CW-1:0] ax, ay, az, bx, by, bz;
		logic [CW-3:0] ra, rb;
	} pair_t;

	typedef struct packed {
		logic hit;
		logic signed [FB+1:0] nx, ny, nz;
		logic signed [CW-1:0] cx, cy, cz;
		logic [CW-2:0] pen;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] centre_a_x = '0, centre_a_y = '0, centre_a_z = '0;
	logic signed [CW-1:0] centre_b_x = '0, centre_b_y = '0, centre_b_z = '0;
	logic [CW-3:0] radius_a = '0, radius_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic signed [FB+1:0] normal_x, normal_y, normal_z;
	logic signed [CW-1:0] contact_x, contact_y, contact_z;
	logic [CW-2:0] penetration;

	contact_t expected_contacts[$];
	int mismatches = 0;
	bit hold_off = 1'b0;

	sphere_sphere_contact_top #(.FRAC_BITS(FB), .COORD_WIDTH(CW)) dut (.*);

	// Clock: 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Floor of the square root of a sum of squares, bit by bit.
	function automatic logic [CW-1:0] floor_root(logic [127:0] s);
		logic [CW-1:0] r;
		logic [CW-1:0] t;
		r = '0;
		for (int b = CW - 1; b >= 0; b--) begin
			t = r | (CW'(1) << b);
			if (128'(t) * 128'(t) <= s)
				r = t;
		end
		return r;
	endfunction

	// One normal component: magnitude over length, rounded half away from zero.
	function automatic logic [FB+1:0] unit_component(logic signed [CW:0] d, logic [CW-1:0] len);
		logic [127:0] q;
		logic [127:0] mag;
		mag = d < 0 ? 128'(-d) : 128'(d);
		q = ((mag << (FB + 1)) / len + 1) >> 1;
		return d < 0 ? -(FB + 2)'(q) : (FB + 2)'(q);
	endfunction

	// Expected contact for one pair of spheres.
	function automatic contact_t predict_contact(pair_t p);
		contact_t c;
		logic signed [CW:0] d[3];
		logic signed [CW:0] sums[3];
		logic [CW:0] mag[3];
		logic [CW-1:0] rsum;
		logic [127:0] s;
		logic [CW-1:0] len;
		c = '0;
		d[0] = p.ax - p.bx; d[1] = p.ay - p.by; d[2] = p.az - p.bz;
		sums[0] = p.ax + p.bx; sums[1] = p.ay + p.by; sums[2] = p.az + p.bz;
		rsum = CW'(p.ra) + CW'(p.rb);
		s = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = d[i] < 0 ? -d[i] : d[i];
			s += 128'(mag[i]) * 128'(mag[i]);
		end
		if (s == 0 || 128'(rsum) * 128'(rsum) <= s)
			return c;
		len = floor_root(s);
		c.hit = 1'b1;
		c.nx = unit_component(d[0], len);
		c.ny = unit_component(d[1], len);
		c.nz = unit_component(d[2], len);
		c.cx = CW'(sums[0] >>> 1);
		c.cy = CW'(sums[1] >>> 1);
		c.cz = CW'(sums[2] >>> 1);
		c.pen = (CW - 1)'(rsum - len);
		return c;
	endfunction

	// Send one pair, after a random gap, and wait for its acceptance.
	task automatic send_pair(pair_t p, int max_gap = 6);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{centre_a_x, centre_a_y, centre_a_z, centre_b_x, centre_b_y, centre_b_z,
			radius_a, radius_b} <= p;
		expected_contacts.insert(expected_contacts.size(), predict_contact(p));
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and wait for every outstanding result.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_contacts.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(int span_bits);
		logic [CW-1:0] v;
		v = $urandom();
		if (span_bits < CW)
			v = CW'($signed(v[CW-1:0] << (CW - span_bits)) >>> (CW - span_bits));
		return v;
	endfunction

	// Random pair whose radius sum is near the centre distance in scale, or one in ten fully random.
	function automatic pair_t rand_pair();
		pair_t p;
		int sb;
		logic [255:0] raw;
		sb = $urandom_range(1, 31);
		p.ax = rand_coord(32); p.ay = rand_coord(32); p.az = rand_coord(32);
		p.bx = p.ax + rand_coord(sb);
		p.by = p.ay + rand_coord(sb);
		p.bz = p.az + rand_coord(sb);
		p.ra = (CW - 2)'($urandom()) >> (CW - 1 - sb);
		p.rb = (CW - 2)'($urandom()) >> (CW - 1 - sb);
		if ($urandom_range(0, 9) == 0) begin
			raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom()};
			p = raw[$bits(pair_t)-1:0];
		end
		return p;
	endfunction

	// Result checker: one result per accepted beat.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			contact_t got, want;
			got = {hit, normal_x, normal_y, normal_z, contact_x, contact_y, contact_z,
				penetration};
			if (expected_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_contacts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected hit=%b n=%0d,%0d,%0d c=%0d,%0d,%0d p=%0d",
							want.hit, want.nx, want.ny, want.nz, want.cx, want.cy,
							want.cz, want.pen);
						$display("          actual   hit=%b n=%0d,%0d,%0d c=%0d,%0d,%0d p=%0d",
							got.hit, got.nx, got.ny, got.nz, got.cx, got.cy,
							got.cz, got.pen);
					end
				end
			end
		end
	end

	// Receiver stalls for a random wait before each beat, or holds off for a long stretch on request.
	initial begin
		int wait_cycles;
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				wait_cycles = $urandom_range(0, 6);
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	task automatic test_directed;
		localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
		localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
		localparam logic [CW-3:0] MAXR = '1;
		// Coincident centres, zero radii, touching exactly, clear overlap, signs and extreme coordinates.
		send_pair('{0, 0, 0, 0, 0, 0, MAXR, MAXR});
		send_pair('{5, 0, 0, 0, 0, 0, (CW-2)'(0), (CW-2)'(0)});
		send_pair('{10, 0, 0, 0, 0, 0, (CW-2)'(5), (CW-2)'(5)});
		send_pair('{10, 0, 0, 0, 0, 0, (CW-2)'(5), (CW-2)'(6)});
		send_pair('{-10, 0, 0, 0, 0, 0, (CW-2)'(5), (CW-2)'(6)});
		send_pair('{0, 3, -4, 0, 0, 0, (CW-2)'(3), (CW-2)'(3)});
		send_pair('{1, 1, 1, 0, 0, 0, (CW-2)'(1), (CW-2)'(1)});
		send_pair('{-1, -1, -1, 0, 0, 0, (CW-2)'(1), (CW-2)'(1)});
		send_pair('{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXR, MAXR});
		send_pair('{MAXC, MAXC, MAXC, MAXC - 7, MAXC, MAXC, MAXR, MAXR});
		send_pair('{MINC, MINC, MINC, MINC + 1, MINC + 1, MINC + 1, MAXR, MAXR});
		send_pair('{MAXC, 0, 0, MAXC - 1, 0, 0, MAXR, (CW-2)'(0)});
		send_pair('{0, 0, 0, CW'(MAXR), CW'(MAXR), CW'(MAXR), MAXR, MAXR});
		send_pair('{-3, 0, 0, 2, 0, 0, MAXR, MAXR});
		send_pair('{1, 2, 2, -1, 0, 0, (CW-2)'(1), (CW-2)'(2)});
		drain();
	endtask

	task automatic test_random;
		for (int n = 0; n < 290; n++)
			send_pair(rand_pair(), ($urandom_range(0, 3) == 0) ? 0 : 6);
	endtask

	// Long receiver hold-off while pairs keep arriving back to back.
	task automatic test_backpressure;
		hold_off = 1'b1;
		for (int n = 0; n < 100; n++)
			send_pair(rand_pair(), 0);
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		drain();
		test_backpressure();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_contacts.size() == 0)
			$display("sphere_sphere_contact_top verification clean");
		else
			$display("sphere_sphere_contact_top verification failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("sphere_sphere_contact_top verification failed");
		$finish;
	end

endmodule

// ===== sphere_sphere_contact_top.f =====
src/ssc_pkg.sv
src/ssc_sqrt.sv
src/ssc_udiv.sv
src/sphere_sphere_contact_top.sv
bench/tb.sv
